@@ rtl/xorshift_range_random_defines.svh @@
// Assertion macros shared by the ranged random generator RTL.
// Depends on nothing; the including module must provide aclk and aresetn.
`ifndef XORSHIFT_RANGE_RANDOM_DEFINES_SVH
`define XORSHIFT_RANGE_RANDOM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define XRR_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, checked outside reset.
`define XRR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/xrr_pkg.sv @@
// Shared constants, types and the xorshift32 step for the ranged random generator.
// Depends on nothing; used by every module of the block.
package xrr_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [DATA_W-1:0] SEED_RESET = 32'hA5A5_A5A5;

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    // Control into the shared modulo unit.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status back from the shared modulo unit.
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    // One full xorshift32 step: three shift-and-xor stages.
    function automatic logic [DATA_W-1:0] xorshift_advance(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] b;
        a = x ^ (x << SHIFT_A);
        b = a ^ (a >> SHIFT_B);
        return b ^ (b << SHIFT_C);
    endfunction

endpackage

@@ rtl/xrr_xorshift.sv @@
// Generator state register with seed reload and single-step xorshift32 advance.
// Depends on xrr_pkg for the data width, the reset seed and the step function.
module xrr_xorshift (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  logic [xrr_pkg::DATA_W-1:0] load_value,
    input  logic                       advance,
    output logic [xrr_pkg::DATA_W-1:0] gen_state
);

    logic [xrr_pkg::DATA_W-1:0] state_reg;
    logic [xrr_pkg::DATA_W-1:0] state_next;

    always_comb begin
        state_next = state_reg;
        if (load) begin
            state_next = load_value;
        end else if (advance) begin
            state_next = xrr_pkg::xorshift_advance(state_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= xrr_pkg::SEED_RESET;
        end else begin
            state_reg <= state_next;
        end
    end

    assign gen_state = state_reg;

endmodule

@@ rtl/xrr_modulo.sv @@
// Radix-2 restoring modulo unit: one shift-and-subtract step per cycle.
// Depends on xrr_pkg for widths and the control and status structs.
module xrr_modulo (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  xrr_pkg::div_ctrl_t         ctrl,
    input  logic [xrr_pkg::DATA_W-1:0] dividend,
    input  logic [xrr_pkg::DATA_W-1:0] divisor,
    output xrr_pkg::div_status_t       status,
    output logic [xrr_pkg::DATA_W-1:0] remainder
);

    logic [xrr_pkg::DATA_W-1:0] rem_reg,  rem_next;
    logic [xrr_pkg::DATA_W-1:0] dvd_reg,  dvd_next;
    logic [xrr_pkg::DATA_W-1:0] dsr_reg,  dsr_next;
    logic [xrr_pkg::CNT_W-1:0]  cnt_reg,  cnt_next;
    logic                       busy_reg, busy_next;
    logic                       done_reg, done_next;

    logic [xrr_pkg::DATA_W:0] trial;
    logic [xrr_pkg::DATA_W:0] diff;
    logic                     fits;

    // The partial remainder stays below the divisor, so one extra bit covers the shift.
    assign trial = {rem_reg, dvd_reg[xrr_pkg::DATA_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_comb begin
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start) begin
            rem_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next = fits ? diff[xrr_pkg::DATA_W-1:0] : trial[xrr_pkg::DATA_W-1:0];
            dvd_next = dvd_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == xrr_pkg::CNT_W'(xrr_pkg::DATA_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign remainder   = rem_reg;

endmodule

@@ rtl/xorshift_range_random.sv @@
// Top level of the ranged xorshift32 random generator.
// Depends on xrr_pkg, xrr_xorshift, xrr_modulo and xorshift_range_random_defines.svh.
//
// Usage:
//   The request channel (s_valid/s_ready) carries one word holding a signed
//   inclusive lower bound s_range_low and a signed exclusive upper bound
//   s_range_high. The result channel (m_valid/m_ready) returns one signed
//   word m_value per request, in request order.
//   The seed channel (cfg_valid/cfg_ready/cfg_data) reloads the generator
//   state with a nonzero seed; a zero seed word is taken and ignored.
//   Seed words are taken only while the block is idle and no request word
//   is being offered.
// Sequencing:
//   A non-empty range advances the xorshift32 state at acceptance, then runs
//   the shared radix-2 modulo unit over every dividend bit and registers the
//   result before it is presented; the next request is taken only once that
//   result has moved to the output register. An empty or inverted range goes
//   straight to the output state with the lower bound and leaves the state
//   untouched.
// Reset and stalls:
//   Synchronous active-low reset loads the state with 0xA5A5A5A5 and empties
//   the output register. A result waits in the output register while the
//   receiver stalls; the next request may already be accepted and computed,
//   and its result is held back until the output register is free.
module xorshift_range_random (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [xrr_pkg::DATA_W-1:0] s_range_low,
    input  logic signed [xrr_pkg::DATA_W-1:0] s_range_high,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [xrr_pkg::DATA_W-1:0] m_value,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic        [xrr_pkg::DATA_W-1:0] cfg_data
);

`include "xorshift_range_random_defines.svh"

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t                     state_reg,   state_next;
    logic [xrr_pkg::DATA_W-1:0] lo_reg,      lo_next;
    logic [xrr_pkg::DATA_W-1:0] span_reg,    span_next;
    logic [xrr_pkg::DATA_W-1:0] result_reg,  result_next;
    logic [xrr_pkg::DATA_W-1:0] m_value_reg, m_value_next;
    logic                       m_valid_reg, m_valid_next;

    logic                       s_accept;
    logic                       range_empty;
    logic                       seed_load;
    logic [xrr_pkg::DATA_W-1:0] gen_state;
    logic [xrr_pkg::DATA_W-1:0] div_rem;
    xrr_pkg::div_ctrl_t         div_ctrl;
    xrr_pkg::div_status_t       div_sts;

    assign s_ready     = (state_reg == ST_IDLE);
    // A seed word never shares an edge with a request word.
    assign cfg_ready   = (state_reg == ST_IDLE) && !s_valid;
    assign s_accept    = s_valid && s_ready;
    assign range_empty = (s_range_high <= s_range_low);
    assign seed_load   = cfg_valid && cfg_ready && (cfg_data != '0);

    // The state advances in the same edge that takes a non-empty request.
    xrr_xorshift u_xorshift (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (seed_load),
        .load_value (cfg_data),
        .advance    (s_accept && !range_empty),
        .gen_state  (gen_state)
    );

    assign div_ctrl.start = (state_reg == ST_START);

    xrr_modulo u_modulo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (div_ctrl),
        .dividend  (gen_state),
        .divisor   (span_reg),
        .status    (div_sts),
        .remainder (div_rem)
    );

    always_comb begin
        state_next   = state_reg;
        lo_next      = lo_reg;
        span_next    = span_reg;
        result_next  = result_reg;
        m_value_next = m_value_reg;
        m_valid_next = m_valid_reg;

        // The receiver taking the word frees the output register.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    lo_next = s_range_low;
                    // Unsigned wrap-around difference; never zero for a non-empty range.
                    span_next = s_range_high - s_range_low;
                    if (range_empty) begin
                        result_next = s_range_low;
                        state_next  = ST_OUT;
                    end else begin
                        state_next = ST_START;
                    end
                end
            end
            ST_START: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_sts.done) begin
                    result_next = lo_reg + div_rem;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_value_next = result_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
        lo_reg      <= lo_next;
        span_reg    <= span_next;
        result_reg  <= result_next;
        m_value_reg <= m_value_next;
    end

    assign m_valid = m_valid_reg;
    assign m_value = m_value_reg;

    // The modulo unit is never running while a new request can be taken.
    `XRR_ASSERT_IMPLY(a_idle_div_free, s_ready, !div_sts.busy)
    // The generator state can never collapse to zero.
    `XRR_ASSERT_IMPLY(a_state_nonzero, 1'b1, gen_state != '0)
    // An empty range leaves the generator state alone.
    `XRR_ASSERT_NEXT(a_empty_keeps_state, s_accept && range_empty,
                     gen_state == $past(gen_state))
    // A finished division always comes back while the sequencer waits for it.
    `XRR_ASSERT_IMPLY(a_done_in_div, div_sts.done, state_reg == ST_DIV)

endmodule

@@ sim/xorshift_range_random_tb.sv @@
// Self-checking testbench for the ranged xorshift32 random generator.
// It depends on xrr_pkg and xorshift_range_random. A built-in predictor checks
// every result word, and both channels stall at random.
`timescale 1ns / 100ps

module xorshift_range_random_tb;

    typedef logic signed [xrr_pkg::DATA_W-1:0] word_t;
    typedef logic        [xrr_pkg::DATA_W-1:0] bits_t;

    // One row of the directed table. Where has_value is set, the expected word
    // is obvious from the bounds: an empty range gives back the lower bound,
    // and a span of one always lands on the lower bound. Every other row is
    // left to the predictor.
    typedef struct packed {
        word_t lo;
        word_t hi;
        logic  has_value;
        word_t value;
    } range_case_t;

    localparam word_t W_MIN = 32'sh8000_0000;
    localparam word_t W_MAX = 32'sh7FFF_FFFF;

    localparam int DIRECTED_N       = 21;
    localparam int PHASES           = 6;
    localparam int ITEMS_PER_PHASE  = 72;
    localparam int LONG_HOLD_AT     = 60;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 5000;
    localparam int SETTLE_CYCLES    = 50;
    localparam int REPORT_LIMIT     = 10;

    range_case_t directed_cases [DIRECTED_N] = '{
        '{32'sd0,          32'sd0,          1'b1, 32'sd0},         // empty at zero
        '{W_MIN,           W_MIN,           1'b1, W_MIN},          // empty at the minimum
        '{W_MAX,           W_MIN,           1'b1, W_MAX},          // fully inverted
        '{W_MAX,           W_MAX,           1'b1, W_MAX},          // empty at the maximum
        '{-32'sd1,         -32'sd2,         1'b1, -32'sd1},        // inverted by one
        '{32'sd0,          32'sd1,          1'b1, 32'sd0},         // span of one
        '{-32'sd1,         32'sd0,          1'b1, -32'sd1},
        '{32'sh7FFF_FFFE,  W_MAX,           1'b1, 32'sh7FFF_FFFE},
        '{W_MIN,           32'sh8000_0001,  1'b1, W_MIN},
        '{W_MIN,           W_MAX,           1'b0, 32'sd0},         // widest span
        '{32'sh8000_0001,  W_MAX,           1'b0, 32'sd0},
        '{-32'sd2,         W_MAX,           1'b0, 32'sd0},
        '{W_MIN,           32'sd0,          1'b0, 32'sd0},         // span of 2^31
        '{32'sd0,          W_MAX,           1'b0, 32'sd0},
        '{-32'sd100,       32'sd100,        1'b0, 32'sd0},
        '{32'sd5,          32'sd6,          1'b1, 32'sd5},
        '{32'sd1000,       -32'sd1000,      1'b1, 32'sd1000},
        '{32'sh7FFF_0000,  32'sh7FFF_0010,  1'b0, 32'sd0},
        '{W_MIN,           32'sd1,          1'b0, 32'sd0},         // span just past 2^31
        '{32'sd12345,      32'sd12345,      1'b1, 32'sd12345},
        '{32'sd0,          32'sd2,          1'b0, 32'sd0}
    };

    logic  aclk;
    logic  aresetn;
    logic  s_valid;
    logic  s_ready;
    word_t s_range_low;
    word_t s_range_high;
    logic  m_valid;
    logic  m_ready;
    word_t m_value;
    logic  cfg_valid;
    logic  cfg_ready;
    bits_t cfg_data;

    // The predictor's copy of the seed register and of the generator state.
    bits_t seed_shadow;
    bits_t gen_state;

    // Expected result words, oldest first.
    word_t pending_values [$];

    int requests_sent;
    int empty_requests;
    int results_seen;
    int seed_words;
    int mismatches;
    int receiver_hold;
    int longest_hold;
    bit long_hold_done;
    bit idling;

    xorshift_range_random uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Runaway guard. It lies far beyond the slowest legal run, so this
    // only fires when the block hangs or drops words.
    initial begin
        #5_000_000;
        $display("xorshift_range_random_tb: errors");
        $finish;
    end

    // One xorshift32 step with shifts 13, 17 and 5.
    function automatic bits_t xorshift_next(input bits_t x);
        bits_t y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction

    // Predicts the word for one accepted request. A non-empty range advances
    // the generator and folds the new state into the span with unsigned
    // arithmetic. An empty or inverted range returns the lower bound and leaves
    // the state alone.
    function automatic word_t predict_draw(input word_t lo, input word_t hi);
        bits_t span;
        if (hi <= lo) begin
            return lo;
        end
        gen_state = xorshift_next(gen_state);
        span = bits_t'(hi) - bits_t'(lo);
        return word_t'(bits_t'(lo) + (gen_state % span));
    endfunction

    // Most gaps are zero or short, and now and then one is long. With
    // idling off, both sides run flat out.
    function automatic int pick_gap();
        int r;
        if (!idling) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    function automatic word_t boundary_word(input int k);
        case (k)
            0: return W_MIN;
            1: return 32'sh8000_0001;
            2: return -32'sd1;
            3: return 32'sd0;
            4: return 32'sd1;
            5: return 32'sh7FFF_FFFE;
            default: return W_MAX;
        endcase
    endfunction

    // Random bounds. Most draws are proper ranges of assorted widths, and the
    // rest are empty, inverted or built from the extreme values.
    task automatic random_bounds(output word_t lo, output word_t hi);
        int kind;
        kind = $urandom_range(0, 9);
        lo = word_t'($urandom);
        case (kind)
            0, 1: hi = word_t'($urandom);
            2, 3, 4: hi = lo + word_t'($urandom_range(1, 2000));
            5: hi = lo + word_t'(32'd1 << $urandom_range(0, 31));
            6: hi = lo - word_t'($urandom_range(0, 50));
            7: begin
                lo = {1'b1, lo[xrr_pkg::DATA_W-2:0]};
                hi = {1'b0, 31'($urandom_range(0, 32'h7FFF_FFFF))};
            end
            8: hi = lo + word_t'($urandom_range(0, 1));
            default: begin
                lo = boundary_word($urandom_range(0, 6));
                hi = boundary_word($urandom_range(0, 6));
            end
        endcase
    endtask

    // Offers one request word and holds it until it is taken. The expectation
    // is queued at the accepting edge. A typed value from the directed table
    // replaces the predicted word, but the predictor still runs so that its
    // state keeps step with the block. After acceptance valid either stays up
    // for the next word or drops for a gap set by gap_after.
    task automatic send_request(input word_t lo, input word_t hi,
                                input logic use_typed, input word_t typed,
                                input int gap_after);
        word_t predicted;
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_range_low  <= lo;
        s_range_high <= hi;
        do @(posedge aclk); while (!s_ready);
        predicted = predict_draw(lo, hi);
        pending_values.push_back(use_typed ? typed : predicted);
        requests_sent++;
        if (hi <= lo) begin
            empty_requests++;
        end
        if (gap_after > 0) begin
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap_after - 1) @(negedge aclk);
        end
    endtask

    // Writes one seed word. A zero word is accepted by the block but changes
    // nothing, and the predictor behaves the same way.
    task automatic write_seed(input bits_t value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (value != '0) begin
            seed_shadow = value;
            gen_state   = value;
        end
        seed_words++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_values.size() != 0) @(posedge aclk);
    endtask

    task automatic check_value(input word_t got);
        word_t want;
        results_seen++;
        if (pending_values.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("unexpected result word %0d: value %0d (0x%08h)",
                         results_seen, got, got);
            end
            return;
        end
        want = pending_values.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("result word %0d: value expected %0d (0x%08h), got %0d (0x%08h)",
                         results_seen, want, want, got, got);
            end
        end
    endtask

    function automatic bits_t phase_seed(input int phase);
        case (phase)
            0: return 32'h0000_0000;    // taken but ignored, so the reset sequence carries on
            1: return 32'h0000_0001;
            2: return 32'hFFFF_FFFF;
            3: return 32'h8000_0000;
            4: return bits_t'($urandom) | 32'h1;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // Receiver. It decides m_ready at each falling edge and takes a word at the
    // rising edge. Once enough results have been seen, it holds off once for a
    // long stretch while the sender keeps offering. The output register and the
    // request behind it then fill up, and s_ready has to drop.
    initial begin
        int gap;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (receiver_hold > 0) begin
                m_ready <= 1'b0;
                receiver_hold--;
            end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
                long_hold_done = 1'b1;
                m_ready       <= 1'b0;
                receiver_hold = LONG_HOLD_CYCLES - 1;
                longest_hold  = LONG_HOLD_CYCLES;
            end else begin
                gap = pick_gap();
                if (gap == 0) begin
                    m_ready <= 1'b1;
                end else begin
                    m_ready <= 1'b0;
                    receiver_hold = gap - 1;
                    if (gap > longest_hold) begin
                        longest_hold = gap;
                    end
                end
            end
            @(posedge aclk);
            if (m_valid && m_ready) begin
                check_value(m_value);
            end
        end
    end

    // Main sequence: reset, the directed table with the reset seed, then
    // random phases with a seed word written before each one.
    initial begin
        word_t lo;
        word_t hi;
        int    waited;
        int    gap;

        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_range_low  = '0;
        s_range_high = '0;
        cfg_valid    = 1'b0;
        cfg_data     = '0;
        idling       = 1'b1;

        requests_sent  = 0;
        empty_requests = 0;
        results_seen   = 0;
        seed_words     = 0;
        mismatches     = 0;
        receiver_hold  = 0;
        longest_hold   = 0;
        long_hold_done = 1'b0;

        seed_shadow = xrr_pkg::SEED_RESET;
        gen_state   = xrr_pkg::SEED_RESET;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // The directed rows run on the reset seed, so the first draws also
        // check the state after reset.
        for (int i = 0; i < DIRECTED_N; i++) begin
            gap = (i == DIRECTED_N - 1) ? 1 : pick_gap();
            send_request(directed_cases[i].lo, directed_cases[i].hi,
                         directed_cases[i].has_value, directed_cases[i].value, gap);
        end
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            // Phase 2 runs with no idling on either side. The long receiver
            // hold falls into the first phase, where the sender keeps pushing.
            idling = (phase != 2);
            write_seed(phase_seed(phase));
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                random_bounds(lo, hi);
                gap = (n == ITEMS_PER_PHASE - 1) ? 1 : pick_gap();
                // Once, the sender stops and waits for every outstanding
                // result before it carries on.
                if (phase == 3 && n == 40) begin
                    gap = 1;
                end
                send_request(lo, hi, 1'b0, '0, gap);
                if (phase == 3 && n == 40) begin
                    wait_drained();
                end
            end
            wait_drained();
        end

        // Drain. Anything still expected after the limit counts as missing,
        // and a stray word during the settle time is caught by the receiver.
        waited = 0;
        while (pending_values.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (pending_values.size() != 0) begin
            $display("%0d expected result words never arrived", pending_values.size());
            mismatches += pending_values.size();
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("run covered %0d requests (%0d empty or inverted) and %0d result words",
                 requests_sent, empty_requests, results_seen);
        $display("%0d seed words written, longest receiver hold %0d cycles, %0d mismatches",
                 seed_words, longest_hold, mismatches);
        if (mismatches == 0) begin
            $display("xorshift_range_random_tb: clean");
        end else begin
            $display("xorshift_range_random_tb: errors");
        end
        $finish;
    end

endmodule
